>>> rtl/ddr_pkg.sv
package ddr_pkg;

  localparam int CFG_W  = 24;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_MOVE_DUTY = 2'd0;
  localparam logic [CIDX_W-1:0] REG_TURN_DUTY = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MOVE_RATE = 2'd2;
  localparam logic [CIDX_W-1:0] REG_TURN_RATE = 2'd3;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [7:0] CH_FWD   = 8'h66;
  localparam logic [7:0] CH_BACK  = 8'h62;
  localparam logic [7:0] CH_LEFT  = 8'h6C;
  localparam logic [7:0] CH_RIGHT = 8'h72;
  localparam logic [7:0] CH_STOP  = 8'h73;

  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4
  } mode_t;

  // cordic datapath: scale 2^30, rounded to 2^20 at the end
  localparam int XW       = 34;
  localparam int CW       = 24;
  localparam int STEP_W   = 5;
  localparam int ATAN_LEN = 24;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032875;
  localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };
  localparam logic [XW-1:0] RND_10 = XW'(512);

  // shared multiplier
  localparam int MA_W   = 25;
  localparam int MB_W   = 24;
  localparam int MUL_W  = MA_W + MB_W;
  localparam int DIST_W = 40;
  localparam int HALF_D = 20;
  localparam int LO_W   = MUL_W - HALF_D;
  localparam logic [MUL_W-1:0] RND_20 = MUL_W'(20'h80000);

endpackage

>>> rtl/ddr_in_if.sv
interface ddr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [7:0]         command_char;
  logic [15:0]        elapsed_ms;
  logic signed [31:0] load_x;
  logic signed [31:0] load_y;
  logic [15:0]        load_heading;

  modport source (
    output valid, operation, command_char, elapsed_ms, load_x, load_y, load_heading,
    input  ready
  );
  modport sink (
    input  valid, operation, command_char, elapsed_ms, load_x, load_y, load_heading,
    output ready
  );
endinterface

>>> rtl/ddr_out_if.sv
interface ddr_out_if #(
  parameter int POSITION_BITS = 32,
  parameter int ANGLE_BITS    = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [8:0]               left_drive;
  logic signed [8:0]               right_drive;
  logic signed [POSITION_BITS-1:0] pos_x;
  logic signed [POSITION_BITS-1:0] pos_y;
  logic [ANGLE_BITS-1:0]           heading;
  logic [2:0]                      motion;
  logic                            unknown_command;

  modport source (
    output valid, left_drive, right_drive, pos_x, pos_y, heading, motion, unknown_command,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, pos_x, pos_y, heading, motion, unknown_command,
    output ready
  );
endinterface

>>> rtl/diff_drive_dead_reckoning_core.sv
// Channel | Dir | Handshake       | Request
// in_ch   | in  | valid / ready   | tick, motion command or pose load
// out_ch  | out | valid / ready   | duties, pose, motion state, unknown flag
// cfg     | in  | cfg_we          | duty and rate registers
//
// Path per request: commands, pose loads and stopped ticks go from ST_IDLE to
// ST_OUT; a turning tick passes ST_TURN; a moving tick passes ST_DIST, the shared
// shift-add CORDIC loop (ST_CORD, ST_FIN), the shared 25x24 multiplier (ST_MUL)
// and ST_UPD. One request at a time: in_ready is high only in idle, and stays low
// while a result waits on out_ready. Synchronous active-low reset clears pose,
// motion state and registers.
module diff_drive_dead_reckoning_core
  import ddr_pkg::*;
#(
  parameter int POSITION_BITS = 32,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  ddr_in_if.sink            in_ch,
  ddr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int DW = MUL_W;
  localparam int SW = ((POSITION_BITS > DW) ? POSITION_BITS : DW) + 1;
  localparam logic signed [SW-1:0] PMAX =
    {{(SW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] PMIN = ~PMAX;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIST = 8'b0000_0010,
    ST_TURN = 8'b0000_0100,
    ST_CORD = 8'b0000_1000,
    ST_FIN  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  function automatic logic [POSITION_BITS-1:0] sat_pos(input logic signed [SW-1:0] v);
    if (v > PMAX) return PMAX[POSITION_BITS-1:0];
    if (v < PMIN) return PMIN[POSITION_BITS-1:0];
    return v[POSITION_BITS-1:0];
  endfunction

  state_t                          state_r, state_nxt;
  logic [7:0]                      move_duty_r, move_duty_nxt;
  logic [7:0]                      turn_duty_r, turn_duty_nxt;
  logic [23:0]                     move_rate_r, move_rate_nxt;
  logic [15:0]                     turn_rate_r, turn_rate_nxt;
  logic signed [POSITION_BITS-1:0] x_r, x_nxt;
  logic signed [POSITION_BITS-1:0] y_r, y_nxt;
  logic [ANGLE_BITS-1:0]           hdg_r, hdg_nxt;
  mode_t                           mode_r, mode_nxt;
  logic                            unk_r, unk_nxt;
  logic [15:0]                     ms_r, ms_nxt;
  logic [DIST_W-1:0]               dist_r, dist_nxt;
  logic signed [XW-1:0]            cx_r, cx_nxt;
  logic signed [XW-1:0]            cy_r, cy_nxt;
  logic signed [XW-1:0]            cz_r, cz_nxt;
  logic                            neg_r, neg_nxt;
  logic [STEP_W-1:0]               step_r, step_nxt;
  logic signed [CW-1:0]            c_r, c_nxt;
  logic signed [CW-1:0]            s_r, s_nxt;
  logic [2:0]                      k_r, k_nxt;
  logic signed [MUL_W-1:0]         prod_r, prod_nxt;
  logic signed [LO_W-1:0]          lo_r, lo_nxt;
  logic signed [DW-1:0]            dx_r, dx_nxt;
  logic signed [DW-1:0]            dy_r, dy_nxt;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MUL_W-1:0] mul_p;
  logic [ANGLE_BITS-1:0]   turn_d;
  logic [31:0]             ang32;
  logic                    ang_neg;
  logic [31:0]             ang_fold;
  logic signed [XW-1:0]    shx, shy, atan_v, xf, yf, xr, yr;
  logic [MUL_W-1:0]        lo_sum;
  logic signed [DW-1:0]    ddx, ddy;
  logic                    moving, turning;

  assign moving  = (mode_r == MODE_FWD) || (mode_r == MODE_BACK);
  assign turning = (mode_r == MODE_LEFT) || (mode_r == MODE_RIGHT);

  // shared multiplier operand select
  always_comb begin
    mul_a = {1'b0, move_rate_r};
    mul_b = {8'b0, ms_r};
    if (state_r == ST_TURN) begin
      mul_a = {9'b0, turn_rate_r};
    end else if (state_r == ST_MUL) begin
      mul_a = k_r[0] ? {5'b0, dist_r[DIST_W-1:HALF_D]} : {5'b0, dist_r[HALF_D-1:0]};
      mul_b = k_r[1] ? s_r : c_r;
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign turn_d = mul_p[8 +: ANGLE_BITS];

  // cordic start angle, folded to [-quarter, quarter)
  assign ang32    = {hdg_r, {(32-ANGLE_BITS){1'b0}}};
  assign ang_neg  = ang32[31] ^ ang32[30];
  assign ang_fold = {ang32[31] ^ ang_neg, ang32[30:0]};

  assign shx    = cx_r >>> step_r;
  assign shy    = cy_r >>> step_r;
  assign atan_v = $signed(XW'(ATAN_TABLE[step_r]));
  assign xf     = neg_r ? -cx_r : cx_r;
  assign yf     = neg_r ? -cy_r : cy_r;
  assign xr     = xf + $signed(RND_10);
  assign yr     = yf + $signed(RND_10);
  assign lo_sum = prod_r + RND_20;
  assign ddx    = (mode_r == MODE_BACK) ? -dx_r : dx_r;
  assign ddy    = (mode_r == MODE_BACK) ? -dy_r : dy_r;

  always_comb begin
    state_nxt     = state_r;
    move_duty_nxt = move_duty_r;
    turn_duty_nxt = turn_duty_r;
    move_rate_nxt = move_rate_r;
    turn_rate_nxt = turn_rate_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    hdg_nxt       = hdg_r;
    mode_nxt      = mode_r;
    unk_nxt       = unk_r;
    ms_nxt        = ms_r;
    dist_nxt      = dist_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    lo_nxt        = lo_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_DUTY: move_duty_nxt = cfg_data[7:0];
        REG_TURN_DUTY: turn_duty_nxt = cfg_data[7:0];
        REG_MOVE_RATE: move_rate_nxt = cfg_data[23:0];
        REG_TURN_RATE: turn_rate_nxt = cfg_data[15:0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ms_nxt   = in_ch.elapsed_ms;
          unk_nxt  = 1'b0;
          cx_nxt   = $signed(XW'(CORDIC_GAIN));
          cy_nxt   = '0;
          cz_nxt   = XW'($signed(ang_fold));
          neg_nxt  = ang_neg;
          step_nxt = '0;
          k_nxt    = '0;
          state_nxt = ST_OUT;
          unique case (in_ch.operation)
            OP_TICK: begin
              if (moving) begin
                state_nxt = ST_DIST;
              end else if (turning) begin
                state_nxt = ST_TURN;
              end
            end
            OP_CMD: begin
              unique case (in_ch.command_char)
                CH_FWD:   mode_nxt = MODE_FWD;
                CH_BACK:  mode_nxt = MODE_BACK;
                CH_LEFT:  mode_nxt = MODE_LEFT;
                CH_RIGHT: mode_nxt = MODE_RIGHT;
                CH_STOP:  mode_nxt = MODE_STOP;
                default:  unk_nxt  = 1'b1;
              endcase
            end
            OP_LOAD: begin
              x_nxt   = sat_pos(SW'(in_ch.load_x));
              y_nxt   = sat_pos(SW'(in_ch.load_y));
              hdg_nxt = ANGLE_BITS'(in_ch.load_heading);
            end
            default: ;
          endcase
        end
      end
      ST_DIST: begin
        dist_nxt  = mul_p[DIST_W-1:0];
        state_nxt = ST_CORD;
      end
      ST_TURN: begin
        hdg_nxt   = (mode_r == MODE_LEFT) ? hdg_r + turn_d : hdg_r - turn_d;
        state_nxt = ST_OUT;
      end
      ST_CORD: begin
        if (!cz_r[XW-1]) begin
          cx_nxt = cx_r - shy;
          cy_nxt = cy_r + shx;
          cz_nxt = cz_r - atan_v;
        end else begin
          cx_nxt = cx_r + shy;
          cy_nxt = cy_r - shx;
          cz_nxt = cz_r + atan_v;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        c_nxt     = xr[XW-1:10];
        s_nxt     = yr[XW-1:10];
        k_nxt     = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // k: 0 lo*c, 1 hi*c, 2 lo*s, 3 hi*s; results fold in from prod_r at the next k
        prod_nxt = mul_p;
        k_nxt    = k_r + 1'b1;
        if (k_r[0]) begin
          lo_nxt = lo_sum[MUL_W-1:HALF_D];
        end
        if (k_r == 3'd2) begin
          dx_nxt = prod_r + DW'(lo_r);
        end
        if (k_r == 3'd4) begin
          dy_nxt    = prod_r + DW'(lo_r);
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        x_nxt     = sat_pos(SW'(x_r) + SW'(ddx));
        y_nxt     = sat_pos(SW'(y_r) + SW'(ddy));
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      move_duty_r <= '0;
      turn_duty_r <= '0;
      move_rate_r <= '0;
      turn_rate_r <= '0;
      x_r         <= '0;
      y_r         <= '0;
      hdg_r       <= '0;
      mode_r      <= MODE_STOP;
      unk_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      move_duty_r <= move_duty_nxt;
      turn_duty_r <= turn_duty_nxt;
      move_rate_r <= move_rate_nxt;
      turn_rate_r <= turn_rate_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      hdg_r       <= hdg_nxt;
      mode_r      <= mode_nxt;
      unk_r       <= unk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ms_r   <= ms_nxt;
    dist_r <= dist_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    k_r    <= k_nxt;
    prod_r <= prod_nxt;
    lo_r   <= lo_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
  end

  // wheel duties follow the motion state
  always_comb begin
    out_ch.left_drive  = '0;
    out_ch.right_drive = '0;
    unique case (mode_r)
      MODE_FWD: begin
        out_ch.left_drive  = {1'b0, move_duty_r};
        out_ch.right_drive = {1'b0, move_duty_r};
      end
      MODE_BACK: begin
        out_ch.left_drive  = -$signed({1'b0, move_duty_r});
        out_ch.right_drive = -$signed({1'b0, move_duty_r});
      end
      MODE_LEFT: begin
        out_ch.left_drive  = -$signed({1'b0, turn_duty_r});
        out_ch.right_drive = {1'b0, turn_duty_r};
      end
      MODE_RIGHT: begin
        out_ch.left_drive  = {1'b0, turn_duty_r};
        out_ch.right_drive = -$signed({1'b0, turn_duty_r});
      end
      default: ;
    endcase
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = (state_r == ST_OUT);
  assign out_ch.pos_x           = x_r;
  assign out_ch.pos_y           = y_r;
  assign out_ch.heading         = hdg_r;
  assign out_ch.motion          = mode_r;
  assign out_ch.unknown_command = unk_r;

endmodule

>>> rtl/ddr_chk.sv
module ddr_chk
  import ddr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] out_left_drive,
  input logic signed [8:0] out_right_drive,
  input logic [2:0]        out_motion,
  input logic              out_unknown_command
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a request was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motion)
      && $stable(out_unknown_command) && $stable(out_left_drive))
    else $error("stalled result changed");

  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motion == MODE_STOP) |-> (out_left_drive == 9'sd0)
      && (out_right_drive == 9'sd0))
    else $error("drive while stopped");

  a_turn_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motion == MODE_LEFT || out_motion == MODE_RIGHT)
      |-> (out_left_drive == -out_right_drive))
    else $error("turn duties not opposite");

endmodule

bind diff_drive_dead_reckoning_core ddr_chk u_ddr_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_left_drive      (out_ch.left_drive),
  .out_right_drive     (out_ch.right_drive),
  .out_motion          (out_ch.motion),
  .out_unknown_command (out_ch.unknown_command)
);

>>> verif/ddr_pose_checker.sv
`timescale 1ns / 100ps
module ddr_pose_checker
  import ddr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ddr_in_if                 in_mon,
  ddr_out_if                out_mon,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                mismatches,
  output int                outstanding
);

  typedef struct {
    logic signed [8:0]  left_drive;
    logic signed [8:0]  right_drive;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic [2:0]         motion;
    logic               unknown_command;
  } pose_report_t;

  localparam int     ROTATIONS = 16;
  localparam longint START_GAIN = 652032875;
  localparam longint POS_MAX = 2147483647;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam longint ARCTAN [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic [7:0]   move_duty;
  logic [7:0]   turn_duty;
  logic [23:0]  move_rate;
  logic [15:0]  turn_rate;
  longint       x_pos;
  longint       y_pos;
  logic [15:0]  head;
  mode_t        drive_mode;
  pose_report_t pending_reports [$];

  function automatic longint clamp_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // cos/sin of the heading at scale 2^20
  task automatic heading_dir(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit          flip;
    longint      z;
    longint      x;
    longint      y;
    longint      nx;
    int          i;
    a = {ang, 16'h0000};
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) a = a + 32'h8000_0000;
    z = longint'(signed'(a));
    x = START_GAIN;
    y = 0;
    for (i = 0; i < ROTATIONS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 512) >>> 10;
    s = (y + 512) >>> 10;
  endtask

  task automatic apply_request(output pose_report_t r);
    longint      travel;
    longint      c;
    longint      s;
    longint      dx;
    longint      dy;
    logic [31:0] turn;
    logic        unknown;
    unknown = 1'b0;
    case (in_mon.operation)
      OP_TICK: begin
        if (drive_mode == MODE_FWD || drive_mode == MODE_BACK) begin
          travel = longint'(move_rate) * longint'(in_mon.elapsed_ms);
          heading_dir(head, c, s);
          dx = (travel * c + 524288) >>> 20;
          dy = (travel * s + 524288) >>> 20;
          if (drive_mode == MODE_BACK) begin
            dx = -dx;
            dy = -dy;
          end
          x_pos = clamp_pos(x_pos + dx);
          y_pos = clamp_pos(y_pos + dy);
        end else if (drive_mode == MODE_LEFT || drive_mode == MODE_RIGHT) begin
          turn = (32'(turn_rate) * 32'(in_mon.elapsed_ms)) >> 8;
          if (drive_mode == MODE_LEFT) head = head + turn[15:0];
          else head = head - turn[15:0];
        end
      end
      OP_CMD: begin
        case (in_mon.command_char)
          CH_FWD:   drive_mode = MODE_FWD;
          CH_BACK:  drive_mode = MODE_BACK;
          CH_LEFT:  drive_mode = MODE_LEFT;
          CH_RIGHT: drive_mode = MODE_RIGHT;
          CH_STOP:  drive_mode = MODE_STOP;
          default:  unknown = 1'b1;
        endcase
      end
      OP_LOAD: begin
        x_pos = longint'(in_mon.load_x);
        y_pos = longint'(in_mon.load_y);
        head  = in_mon.load_heading;
      end
      default: ;
    endcase

    r.left_drive  = '0;
    r.right_drive = '0;
    case (drive_mode)
      MODE_FWD: begin
        r.left_drive  = {1'b0, move_duty};
        r.right_drive = {1'b0, move_duty};
      end
      MODE_BACK: begin
        r.left_drive  = -$signed({1'b0, move_duty});
        r.right_drive = -$signed({1'b0, move_duty});
      end
      MODE_LEFT: begin
        r.left_drive  = -$signed({1'b0, turn_duty});
        r.right_drive = {1'b0, turn_duty};
      end
      MODE_RIGHT: begin
        r.left_drive  = {1'b0, turn_duty};
        r.right_drive = -$signed({1'b0, turn_duty});
      end
      default: ;
    endcase
    r.pos_x           = x_pos[31:0];
    r.pos_y           = y_pos[31:0];
    r.heading         = head;
    r.motion          = drive_mode;
    r.unknown_command = unknown;
  endtask

  always @(posedge clk) begin : monitor
    pose_report_t want;
    pose_report_t got;
    if (!rst_n) begin
      move_duty  = '0;
      turn_duty  = '0;
      move_rate  = '0;
      turn_rate  = '0;
      x_pos      = 0;
      y_pos      = 0;
      head       = '0;
      drive_mode = MODE_STOP;
      mismatches = 0;
      pending_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MOVE_DUTY: move_duty = cfg_data[7:0];
          REG_TURN_DUTY: turn_duty = cfg_data[7:0];
          REG_MOVE_RATE: move_rate = cfg_data[23:0];
          REG_TURN_RATE: turn_rate = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        apply_request(want);
        pending_reports.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.left_drive      = out_mon.left_drive;
        got.right_drive     = out_mon.right_drive;
        got.pos_x           = out_mon.pos_x;
        got.pos_y           = out_mon.pos_y;
        got.heading         = out_mon.heading;
        got.motion          = out_mon.motion;
        got.unknown_command = out_mon.unknown_command;
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: x=%0d y=%0d h=%0d m=%0d",
                     $time, got.pos_x, got.pos_y, got.heading, got.motion);
        end else begin
          want = pending_reports.pop_front();
          if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
              got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
              got.heading !== want.heading || got.motion !== want.motion ||
              got.unknown_command !== want.unknown_command) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected L=%0d R=%0d x=%0d y=%0d h=%0d m=%0d u=%0b",
                       $time, want.left_drive, want.right_drive, want.pos_x, want.pos_y,
                       want.heading, want.motion, want.unknown_command);
              $display("%0t:          actual   L=%0d R=%0d x=%0d y=%0d h=%0d m=%0d u=%0b",
                       $time, got.left_drive, got.right_drive, got.pos_x, got.pos_y,
                       got.heading, got.motion, got.unknown_command);
            end
          end
        end
      end
    end
    outstanding <= pending_reports.size();
  end

endmodule

>>> verif/diff_drive_dead_reckoning_core_test.sv
`timescale 1ns / 100ps
module diff_drive_dead_reckoning_core_test;
  import ddr_pkg::*;

  localparam int         REQUESTS  = 700;
  localparam int         PHASES    = 8;
  localparam int         WATCHDOG  = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  int                mismatches;
  int                outstanding;
  int                stall_left = 0;
  int                quiet_cycles = 0;
  bit                calm = 1'b0;

  ddr_in_if  in_ch ();
  ddr_out_if out_ch ();

  diff_drive_dead_reckoning_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ddr_pose_checker pose_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_ms();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 16'($urandom_range(0, 40));
    if (pick < 90) return 16'($urandom_range(0, 2000));
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] pick_pos();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
  endfunction

  function automatic logic [7:0] motion_char();
    case ($urandom_range(0, 4))
      0: return CH_FWD;
      1: return CH_BACK;
      2: return CH_LEFT;
      3: return CH_RIGHT;
      default: return CH_STOP;
    endcase
  endfunction

  // result side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = idle_span() - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] op, input logic [7:0] ch, input logic [15:0] ms,
                          input logic [31:0] lx, input logic [31:0] ly,
                          input logic [15:0] lh);
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.operation    = op;
    in_ch.command_char = ch;
    in_ch.elapsed_ms   = ms;
    in_ch.load_x       = lx;
    in_ch.load_y       = ly;
    in_ch.load_heading = lh;
    do @(posedge clk); while (!in_ch.ready);
    if (!calm && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (idle_span() - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // unused upper data bits carry noise
  task automatic configure(input logic [7:0] md, input logic [7:0] td,
                           input logic [23:0] mr, input logic [15:0] tr);
    set_reg(REG_MOVE_DUTY, {16'($urandom()), md});
    set_reg(REG_TURN_DUTY, {16'($urandom()), td});
    set_reg(REG_MOVE_RATE, mr);
    set_reg(REG_TURN_RATE, {8'($urandom()), tr});
  endtask

  // command followed by a run of ticks, with loads and noise mixed in
  task automatic random_burst(inout int served);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_req(OP_UNUSED, 8'($urandom()), 16'($urandom()), $urandom(), $urandom(),
               16'($urandom()));
    end else if (pick < 8) begin
      send_req(OP_CMD, 8'($urandom()), 16'($urandom()), $urandom(), $urandom(),
               16'($urandom()));
    end else if (pick < 20) begin
      send_req(OP_LOAD, 8'($urandom()), 16'($urandom()), pick_pos(), pick_pos(),
               16'($urandom()));
      served++;
    end else begin
      send_req(OP_CMD, motion_char(), 16'($urandom()), $urandom(), $urandom(),
               16'($urandom()));
      served++;
      repeat ($urandom_range(1, 6)) begin
        send_req(OP_TICK, 8'($urandom()), pick_ms(), $urandom(), $urandom(),
                 16'($urandom()));
        served++;
      end
    end
  endtask

  initial begin
    int served;
    int phase;
    int target;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_TICK;
    in_ch.command_char = '0;
    in_ch.elapsed_ms   = '0;
    in_ch.load_x       = '0;
    in_ch.load_y       = '0;
    in_ch.load_heading = '0;
    served = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    configure(8'hFF, 8'h01, 24'hFF_FFFF, 16'hFFFF);
    send_req(OP_TICK, 8'h00, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_req(OP_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(OP_CMD, 8'h00, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_CMD, 8'hFF, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_CMD, CH_FWD, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'h0000, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_req(OP_LOAD, 8'h00, 16'h0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_req(OP_CMD, CH_BACK, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_req(OP_CMD, CH_LEFT, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_req(OP_CMD, CH_RIGHT, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'hFFFF, 32'h0, 32'h0, 16'h0);
    send_req(OP_LOAD, 8'h00, 16'h0, 32'h0, 32'h0, 16'h4000);
    send_req(OP_CMD, CH_FWD, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'd1000, 32'h0, 32'h0, 16'h0);
    send_req(OP_LOAD, 8'h00, 16'h0, 32'h0, 32'h0, 16'h8000);
    send_req(OP_TICK, 8'h00, 16'd1000, 32'h0, 32'h0, 16'h0);
    send_req(OP_LOAD, 8'h00, 16'h0, 32'h0, 32'h0, 16'hC000);
    send_req(OP_TICK, 8'h00, 16'd1000, 32'h0, 32'h0, 16'h0);
    send_req(OP_CMD, CH_STOP, 16'h0, 32'h0, 32'h0, 16'h0);
    settle();
    configure(8'h00, 8'h00, 24'h0, 16'h0);
    send_req(OP_CMD, CH_FWD, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'd1000, 32'h0, 32'h0, 16'h0);
    send_req(OP_CMD, CH_LEFT, 16'h0, 32'h0, 32'h0, 16'h0);
    send_req(OP_TICK, 8'h00, 16'd1000, 32'h0, 32'h0, 16'h0);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: configure(8'hFF, 8'hFF, 24'hFF_FFFF, 16'hFFFF);
        1: configure(8'h00, 8'h00, 24'h0, 16'h0);
        2: configure(8'h01, 8'h80, 24'($urandom_range(0, 262144)),
                     16'($urandom()));
        default: configure(8'($urandom()), 8'($urandom()),
                           ($urandom_range(0, 1) == 0) ? 24'($urandom())
                                                       : 24'($urandom_range(0, 65536)),
                           16'($urandom()));
      endcase
      calm = (phase % 4 == 3);
      target = REQUESTS * (phase + 1) / PHASES;
      while (served < target) random_burst(served);
    end
    calm = 1'b0;
    settle();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
